FILE: rtl/core/ljpfa_pkg.sv
// shared types and codes for the lennard-jones pair force accumulator
// depends on nothing; imported by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package ljpfa_pkg;

  // field widths
  localparam int POS_W = 32;
  localparam int ACC_W = 48;
  localparam int IDX_W = 6;

  // request codes
  localparam logic [1:0] REQ_LOAD     = 2'd0;
  localparam logic [1:0] REQ_INTERACT = 2'd1;
  localparam logic [1:0] REQ_READ     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SIGMA_SIXTH  = 2'd0;
  localparam logic [1:0] CFG_CUTOFF_SQ    = 2'd1;
  localparam logic [1:0] CFG_EPSILON      = 2'd2;
  localparam logic [1:0] CFG_ENERGY_SHIFT = 2'd3;

  // arithmetic steps of one pair
  typedef enum logic [3:0] {
    OP_SQX,
    OP_SQY,
    OP_SQZ,
    OP_R6,
    OP_EMUL,
    OP_AMUL,
    OP_ADIV,
    OP_CMUL,
    OP_FX,
    OP_FY,
    OP_FZ
  } op_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic latch_n;
    logic rd;
    logic diff;
    logic go;
    op_t  op;
    logic add_e;
    logic wb;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_done;
    logic in_range;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/ljpfa_mul.sv
// multi-cycle 64x64 unsigned multiplier built on one 32x32 multiplier
// four partial products, each registered before it is added; no package use
`timescale 1ns / 1ps
`default_nettype none

module ljpfa_mul (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic      [127:0] prod,
  output logic              done
);

  logic [2:0]   cnt_r;
  logic [2:0]   prev;
  logic         busy_r;
  logic         done_r;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [63:0]  pp_r;
  logic [127:0] acc_r;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [127:0] pp_shifted;

  // operand halves for the current step, shift for the previous one
  always_comb begin
    a_half = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    b_half = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    prev   = cnt_r - 3'd1;
    case (prev[1:0])
      2'd0:       pp_shifted = {64'd0, pp_r};
      2'd1, 2'd2: pp_shifted = {32'd0, pp_r, 32'd0};
      default:    pp_shifted = {pp_r, 64'd0};
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // partial products and sum
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != 3'd4) begin
        pp_r <= 64'(a_half) * 64'(b_half);
      end
      if (cnt_r != 3'd0) begin
        acc_r <= acc_r + pp_shifted;
      end
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

`default_nettype wire

FILE: rtl/core/ljpfa_div.sv
// restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle
// no package use; divisor must be nonzero
`timescale 1ns / 1ps
`default_nettype none

module ljpfa_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [31:0] den,
  output logic      [63:0] quo,
  output logic             done
);

  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] q_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        ge;

  // one trial subtraction
  always_comb begin
    rem_sh = {rem_r, q_r[63]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = rem_sh >= {1'b0, den_r};
  end

  // iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : rem_sh[31:0];
      q_r   <= {q_r[62:0], ge};
    end
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule

`default_nettype wire

FILE: rtl/core/ljpfa_dp.sv
// datapath: config registers, atom memories, pair arithmetic and sums
// depends on ljpfa_pkg, ljpfa_mul and ljpfa_div
`timescale 1ns / 1ps
`default_nettype none

module ljpfa_dp #(
  parameter int MAX_ATOMS = 64,
  parameter int AW        = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ljpfa_pkg::ctrl_cmd_t        cmd,
  input  wire logic [AW-1:0]               addr,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [31:0]                 cfg_wdata,
  input  wire logic signed [31:0]          in_pos_x,
  input  wire logic signed [31:0]          in_pos_y,
  input  wire logic signed [31:0]          in_pos_z,
  output ljpfa_pkg::dp_status_t            status,
  output logic signed [47:0]               rd_force_x,
  output logic signed [47:0]               rd_force_y,
  output logic signed [47:0]               rd_force_z,
  output logic signed [47:0]               rd_energy
);

  import ljpfa_pkg::*;

  localparam logic [61:0] INTER_MAX = '1;
  localparam logic [31:0] R6_MAX    = '1;
  localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [36:0] SIX_Q16   = 37'h00_0006_0000;
  localparam logic signed [63:0] ACC_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN64 = 64'shFFFF_8000_0000_0000;
  localparam logic [ACC_W-1:0]   ACC_MAX_V = 48'h7FFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0]   ACC_MIN_V = 48'h8000_0000_0000;

  function automatic logic [ACC_W-1:0] sat_acc(input logic signed [63:0] v);
    logic [ACC_W-1:0] res;
    if (v > ACC_MAX64) begin
      res = ACC_MAX_V;
    end else if (v < ACC_MIN64) begin
      res = ACC_MIN_V;
    end else begin
      res = v[ACC_W-1:0];
    end
    return res;
  endfunction

  // configuration
  logic [31:0] sigma_r;
  logic [31:0] cutoff_r;
  logic [31:0] eps_r;
  logic [31:0] eshift_r;

  // atom memories
  logic [POS_W-1:0] pos_x_mem [MAX_ATOMS];
  logic [POS_W-1:0] pos_y_mem [MAX_ATOMS];
  logic [POS_W-1:0] pos_z_mem [MAX_ATOMS];
  logic [ACC_W-1:0] fx_mem    [MAX_ATOMS];
  logic [ACC_W-1:0] fy_mem    [MAX_ATOMS];
  logic [ACC_W-1:0] fz_mem    [MAX_ATOMS];
  logic [ACC_W-1:0] en_mem    [MAX_ATOMS];

  logic [POS_W-1:0] rd_px_r, rd_py_r, rd_pz_r;
  logic [ACC_W-1:0] rd_fx_r, rd_fy_r, rd_fz_r, rd_en_r;

  // pair working registers
  logic [POS_W-1:0] nx_r, ny_r, nz_r;
  logic [31:0]      dmag_x_r, dmag_y_r, dmag_z_r;
  logic             dneg_x_r, dneg_y_r, dneg_z_r;
  logic [ACC_W-1:0] wk_fx_r, wk_fy_r, wk_fz_r, wk_en_r;
  logic [49:0]      r2_r;
  logic [31:0]      r6_r;
  logic [58:0]      e_r;
  logic [47:0]      a_r;
  logic [61:0]      a1_r;
  logic [61:0]      c_mag_r;
  logic             c_neg_r;
  op_t              op_r;

  // combinational terms
  logic [32:0]  dx, dy, dz, dx_neg, dy_neg, dz_neg;
  logic [32:0]  r6m1, r6m1_abs;
  logic         r6m1_neg;
  logic [37:0]  cb, cb_abs;
  logic         cb_neg;
  logic [63:0]  mul_a, mul_b, div_num;
  logic         mul_go, div_go;
  logic [127:0] prod;
  logic         mul_done;
  logic [63:0]  quo;
  logic         div_done;
  logic         ovf;
  logic [47:0]  pr16;
  logic [55:0]  pr8;
  logic [58:0]  t_e, es_e, e0, e_half;
  logic [63:0]  e_sum;
  logic [61:0]  fm;
  logic         fneg;
  logic [63:0]  fv;
  logic [ACC_W-1:0] f_wk;
  logic         f_dneg;
  logic [ACC_W-1:0] f_new;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r  <= '0;
      cutoff_r <= '0;
      eps_r    <= '0;
      eshift_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIGMA_SIXTH:  sigma_r  <= cfg_wdata;
        CFG_CUTOFF_SQ:    cutoff_r <= cfg_wdata;
        CFG_EPSILON:      eps_r    <= cfg_wdata;
        CFG_ENERGY_SHIFT: eshift_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x_mem[addr] <= in_pos_x;
      pos_y_mem[addr] <= in_pos_y;
      pos_z_mem[addr] <= in_pos_z;
      fx_mem[addr]    <= '0;
      fy_mem[addr]    <= '0;
      fz_mem[addr]    <= '0;
      en_mem[addr]    <= '0;
    end else if (cmd.wb) begin
      fx_mem[addr] <= wk_fx_r;
      fy_mem[addr] <= wk_fy_r;
      fz_mem[addr] <= wk_fz_r;
      en_mem[addr] <= wk_en_r;
    end
    if (cmd.rd) begin
      rd_px_r <= pos_x_mem[addr];
      rd_py_r <= pos_y_mem[addr];
      rd_pz_r <= pos_z_mem[addr];
      rd_fx_r <= fx_mem[addr];
      rd_fy_r <= fy_mem[addr];
      rd_fz_r <= fz_mem[addr];
      rd_en_r <= en_mem[addr];
    end
  end

  // distance, terms of r6 and unit operands
  always_comb begin
    dx     = {rd_px_r[31], rd_px_r} - {nx_r[31], nx_r};
    dy     = {rd_py_r[31], rd_py_r} - {ny_r[31], ny_r};
    dz     = {rd_pz_r[31], rd_pz_r} - {nz_r[31], nz_r};
    dx_neg = 33'd0 - dx;
    dy_neg = 33'd0 - dy;
    dz_neg = 33'd0 - dz;

    r6m1     = {1'b0, r6_r} - {1'b0, ONE_Q16};
    r6m1_neg = r6m1[32];
    r6m1_abs = r6m1_neg ? (33'd0 - r6m1) : r6m1;

    cb     = {3'b000, r6_r, 3'b000} + {4'b0000, r6_r, 2'b00} - {1'b0, SIX_Q16};
    cb_neg = cb[37];
    cb_abs = cb_neg ? (38'd0 - cb) : cb;

    mul_a   = '0;
    mul_b   = '0;
    case (cmd.op)
      OP_SQX:  begin mul_a = {32'd0, dmag_x_r}; mul_b = {32'd0, dmag_x_r}; end
      OP_SQY:  begin mul_a = {32'd0, dmag_y_r}; mul_b = {32'd0, dmag_y_r}; end
      OP_SQZ:  begin mul_a = {32'd0, dmag_z_r}; mul_b = {32'd0, dmag_z_r}; end
      OP_EMUL: begin mul_a = {32'd0, r6_r};     mul_b = {32'd0, r6m1_abs[31:0]}; end
      OP_AMUL: begin mul_a = {32'd0, eps_r};    mul_b = {32'd0, r6_r}; end
      OP_CMUL: begin mul_a = {2'd0, a1_r};      mul_b = {27'd0, cb_abs[36:0]}; end
      OP_FX:   begin mul_a = {32'd0, dmag_x_r}; mul_b = {2'd0, c_mag_r}; end
      OP_FY:   begin mul_a = {32'd0, dmag_y_r}; mul_b = {2'd0, c_mag_r}; end
      OP_FZ:   begin mul_a = {32'd0, dmag_z_r}; mul_b = {2'd0, c_mag_r}; end
      default: ;
    endcase
    div_num = (cmd.op == OP_ADIV) ? {a_r, 16'd0} : {16'd0, r6_r, 16'd0};
    div_go  = cmd.go && (cmd.op inside {OP_R6, OP_ADIV});
    mul_go  = cmd.go && !(cmd.op inside {OP_R6, OP_ADIV});
  end

  ljpfa_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .done  (mul_done)
  );

  ljpfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_num),
    .den   (r2_r[31:0]),
    .quo   (quo),
    .done  (div_done)
  );

  // product views, energy term and force term
  always_comb begin
    ovf  = |prod[127:64];
    pr16 = prod[63:16];
    pr8  = prod[63:8];

    t_e    = r6m1_neg ? (59'd0 - {3'b000, pr8}) : {3'b000, pr8};
    es_e   = {{19{eshift_r[31]}}, eshift_r, 8'd0};
    e0     = t_e - es_e;
    e_half = $signed(e0 + {58'd0, e0[58]}) >>> 1;
    e_sum  = {{5{e_r[58]}}, e_r} + {{16{wk_en_r[47]}}, wk_en_r};

    case (op_r)
      OP_FY:   begin f_wk = wk_fy_r; f_dneg = dneg_y_r; end
      OP_FZ:   begin f_wk = wk_fz_r; f_dneg = dneg_z_r; end
      default: begin f_wk = wk_fx_r; f_dneg = dneg_x_r; end
    endcase
    fm    = ovf ? INTER_MAX : {6'd0, pr8};
    fneg  = f_dneg ^ c_neg_r;
    fv    = fneg ? (64'd0 - {2'd0, fm}) : {2'd0, fm};
    f_new = sat_acc($signed(fv + {{16{f_wk[47]}}, f_wk}));
  end

  // op tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_SQX;
    end else if (cmd.go) begin
      op_r <= cmd.op;
    end
  end

  // pair registers
  always_ff @(posedge clk) begin
    if (cmd.latch_n) begin
      nx_r <= in_pos_x;
      ny_r <= in_pos_y;
      nz_r <= in_pos_z;
    end
    if (cmd.diff) begin
      dmag_x_r <= dx[32] ? dx_neg[31:0] : dx[31:0];
      dmag_y_r <= dy[32] ? dy_neg[31:0] : dy[31:0];
      dmag_z_r <= dz[32] ? dz_neg[31:0] : dz[31:0];
      dneg_x_r <= dx[32];
      dneg_y_r <= dy[32];
      dneg_z_r <= dz[32];
      wk_fx_r  <= rd_fx_r;
      wk_fy_r  <= rd_fy_r;
      wk_fz_r  <= rd_fz_r;
      wk_en_r  <= rd_en_r;
      r2_r     <= '0;
      r6_r     <= sigma_r;
    end
    if (cmd.add_e) begin
      wk_en_r <= sat_acc($signed(e_sum));
    end
    if (mul_done) begin
      case (op_r)
        OP_SQX, OP_SQY, OP_SQZ: r2_r <= r2_r + {2'd0, pr16};
        OP_EMUL: e_r <= e_half;
        OP_AMUL: a_r <= pr16;
        OP_CMUL: begin
          c_mag_r <= ovf ? INTER_MAX : {14'd0, pr16};
          c_neg_r <= cb_neg;
        end
        OP_FX: wk_fx_r <= f_new;
        OP_FY: wk_fy_r <= f_new;
        OP_FZ: wk_fz_r <= f_new;
        default: ;
      endcase
    end
    if (div_done) begin
      if (op_r == OP_ADIV) begin
        a1_r <= (|quo[63:62]) ? INTER_MAX : quo[61:0];
      end else begin
        r6_r <= (|quo[63:32]) ? R6_MAX : quo[31:0];
      end
    end
  end

  // status and read data
  assign status.op_done  = mul_done | div_done;
  assign status.in_range = (r2_r != 50'd0) && (r2_r <= {18'd0, cutoff_r});
  assign rd_force_x = rd_fx_r;
  assign rd_force_y = rd_fy_r;
  assign rd_force_z = rd_fz_r;
  assign rd_energy  = rd_en_r;

endmodule

`default_nettype wire

FILE: rtl/core/ljpfa_ctrl.sv
// controller: request decode, home atom loop and step sequencing of one pair
// depends on ljpfa_pkg
`timescale 1ns / 1ps
`default_nettype none

module ljpfa_ctrl #(
  parameter int MAX_ATOMS = 64,
  parameter int AW        = 6,
  parameter int CW        = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_req_type,
  input  wire logic [5:0]           in_atom_index,
  input  wire logic                 in_skip_valid,
  input  wire ljpfa_pkg::dp_status_t status,
  output ljpfa_pkg::ctrl_cmd_t      cmd,
  output logic [AW-1:0]             addr,
  output logic                      out_valid,
  output logic [5:0]                out_read_index
);

  import ljpfa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RDOUT = 8'b0000_0010,
    S_NEXT  = 8'b0000_0100,
    S_DIFF  = 8'b0000_1000,
    S_GO    = 8'b0001_0000,
    S_WAIT  = 8'b0010_0000,
    S_CHECK = 8'b0100_0000,
    S_WB    = 8'b1000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] h_r, h_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [5:0]    idx_r, idx_nxt;
  logic          skip_r, skip_nxt;
  op_t           op_r, op_nxt;
  logic [1:0]    r6cnt_r, r6cnt_nxt;
  logic          idx_ok;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    skip_nxt  = skip_r;
    op_nxt    = op_r;
    r6cnt_nxt = r6cnt_r;
    cmd       = '0;
    cmd.op    = op_r;
    addr      = h_r[AW-1:0];
    out_valid = 1'b0;
    idx_ok    = int'(in_atom_index) < MAX_ATOMS;

    case (state_r)
      S_IDLE: begin
        addr = AW'(in_atom_index);
        if (start) begin
          case (in_req_type)
            REQ_LOAD: begin
              if (idx_ok) begin
                cmd.load  = 1'b1;
                count_nxt = CW'(in_atom_index) + CW'(1);
              end
            end
            REQ_INTERACT: begin
              cmd.latch_n = 1'b1;
              idx_nxt     = in_atom_index;
              skip_nxt    = in_skip_valid;
              h_nxt       = '0;
              state_nxt   = S_NEXT;
            end
            REQ_READ: begin
              if (idx_ok) begin
                cmd.rd    = 1'b1;
                idx_nxt   = in_atom_index;
                state_nxt = S_RDOUT;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDOUT: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      // walk the loaded home atoms
      S_NEXT: begin
        if (h_r >= count_r) begin
          state_nxt = S_IDLE;
        end else if (skip_r && (int'(h_r) == int'(idx_r))) begin
          h_nxt = h_r + CW'(1);
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        op_nxt    = OP_SQX;
        state_nxt = S_GO;
      end
      S_GO: begin
        cmd.go    = 1'b1;
        cmd.add_e = (op_r == OP_AMUL);
        state_nxt = S_WAIT;
      end
      // step order of one pair
      S_WAIT: begin
        if (status.op_done) begin
          state_nxt = S_GO;
          case (op_r)
            OP_SQX:  op_nxt = OP_SQY;
            OP_SQY:  op_nxt = OP_SQZ;
            OP_SQZ:  state_nxt = S_CHECK;
            OP_R6: begin
              if (r6cnt_r == 2'd2) begin
                op_nxt = OP_EMUL;
              end else begin
                r6cnt_nxt = r6cnt_r + 2'd1;
              end
            end
            OP_EMUL: op_nxt = OP_AMUL;
            OP_AMUL: op_nxt = OP_ADIV;
            OP_ADIV: op_nxt = OP_CMUL;
            OP_CMUL: op_nxt = OP_FX;
            OP_FX:   op_nxt = OP_FY;
            OP_FY:   op_nxt = OP_FZ;
            OP_FZ:   state_nxt = S_WB;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      // cutoff and coincidence test
      S_CHECK: begin
        if (status.in_range) begin
          op_nxt    = OP_R6;
          r6cnt_nxt = 2'd0;
          state_nxt = S_GO;
        end else begin
          h_nxt     = h_r + CW'(1);
          state_nxt = S_NEXT;
        end
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        h_nxt     = h_r + CW'(1);
        state_nxt = S_NEXT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      h_r     <= '0;
      count_r <= '0;
      idx_r   <= '0;
      skip_r  <= 1'b0;
      op_r    <= OP_SQX;
      r6cnt_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      h_r     <= h_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      skip_r  <= skip_nxt;
      op_r    <= op_nxt;
      r6cnt_r <= r6cnt_nxt;
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_read_index = idx_r;

  // checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    status.op_done |-> (state_r == S_WAIT))
    else $error("unit finished outside the wait state");

  a_h_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NEXT) |-> (h_r <= count_r))
    else $error("home atom counter ran past the loaded set");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_READ) && idx_ok) |=> out_valid)
    else $error("read item gave no result");

endmodule

`default_nettype wire

FILE: rtl/core/lennard_jones_pair_force_accumulator.sv
// lennard-jones 12-6 force and energy accumulator, top level
// load: busy stays low. read: result strobe in the cycle after accept.
// interact: home atoms in the cutoff run all steps, ones outside end after the squares,
// skipped ones are passed over; four divider steps per pair. one item at a time.
// synchronous active-low reset clears control and config; atom memories hold until loaded.
// depends on ljpfa_pkg, ljpfa_ctrl, ljpfa_dp
`timescale 1ns / 1ps
`default_nettype none

module lennard_jones_pair_force_accumulator #(
  parameter int MAX_ATOMS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [5:0]         in_atom_index,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic               in_skip_valid,
  output logic                    out_valid,
  output logic [5:0]              out_read_index,
  output logic signed [47:0]      out_force_x,
  output logic signed [47:0]      out_force_y,
  output logic signed [47:0]      out_force_z,
  output logic signed [47:0]      out_energy,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);

  import ljpfa_pkg::*;

  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CW = $clog2(MAX_ATOMS + 1);

  ctrl_cmd_t     cmd;
  dp_status_t    status;
  logic [AW-1:0] addr;

  ljpfa_ctrl #(
    .MAX_ATOMS (MAX_ATOMS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_atom_index  (in_atom_index),
    .in_skip_valid  (in_skip_valid),
    .status         (status),
    .cmd            (cmd),
    .addr           (addr),
    .out_valid      (out_valid),
    .out_read_index (out_read_index)
  );

  ljpfa_dp #(
    .MAX_ATOMS (MAX_ATOMS),
    .AW        (AW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .addr       (addr),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_pos_z   (in_pos_z),
    .status     (status),
    .rd_force_x (out_force_x),
    .rd_force_y (out_force_y),
    .rd_force_z (out_force_z),
    .rd_energy  (out_energy)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// self-checking testbench for the lennard-jones pair force accumulator
// depends on ljpfa_pkg and lennard_jones_pair_force_accumulator; bit-exact predictor inside
`timescale 1ns / 1ps

module tb;
  import ljpfa_pkg::*;

  localparam int  NUM_ATOMS  = 64;
  localparam int  CYCLE_CAP  = 160000000;
  localparam longint unsigned SAT62 = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -64'sh0000_8000_0000_0000;
  localparam longint ONE_Q  = 65536;

  typedef struct {
    logic [1:0]         req;
    logic [5:0]         idx;
    logic signed [31:0] x, y, z;
    logic               skip;
  } item_t;

  typedef struct {
    logic [5:0]         idx;
    logic signed [47:0] fx, fy, fz, en;
  } sums_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = '0;
  logic [5:0] in_atom_index = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic in_skip_valid = 1'b0;
  logic out_valid;
  logic [5:0] out_read_index;
  logic signed [47:0] out_force_x, out_force_y, out_force_z, out_energy;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  lennard_jones_pair_force_accumulator #(.MAX_ATOMS(NUM_ATOMS)) DUT (
    .clk, .rst_n, .start, .busy,
    .in_req_type, .in_atom_index, .in_pos_x, .in_pos_y, .in_pos_z, .in_skip_valid,
    .out_valid, .out_read_index, .out_force_x, .out_force_y, .out_force_z, .out_energy,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always #5 clk = ~clk;

  // predictor state
  longint unsigned sig6, cut2, eps4;
  longint eshift;
  longint hx[NUM_ATOMS], hy[NUM_ATOMS], hz[NUM_ATOMS];
  longint ax[NUM_ATOMS], ay[NUM_ATOMS], az[NUM_ATOMS], ae[NUM_ATOMS];
  int unsigned atom_count;

  item_t pending[$];
  sums_t sums_q[$];
  item_t cur;
  bit hold = 0, took = 0, burst = 0;
  int gap = 0;
  int fails = 0;
  int cycles = 0;

  // generator side view of the loaded entries: one past the highest loaded index
  int loaded = 0;

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint clamp62(longint unsigned m, bit neg);
    if (m > SAT62) m = SAT62;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint qmul(longint a, longint b, int sh);
    logic [127:0] p;
    longint unsigned ma, mb;
    bit neg;
    ma = mag64(a);
    mb = mag64(b);
    neg = (a < 0) != (b < 0);
    p = {64'd0, ma} * {64'd0, mb};
    if (p[127:64] != 0) return clamp62(64'hFFFF_FFFF_FFFF_FFFF, neg);
    return clamp62(p[63:0] >> sh, neg);
  endfunction

  function automatic longint qdiv(longint a, longint unsigned d);
    longint unsigned ma, p;
    ma = mag64(a);
    if (ma > (64'hFFFF_FFFF_FFFF_FFFF >> 16)) p = 64'hFFFF_FFFF_FFFF_FFFF;
    else p = (ma << 16) / d;
    return clamp62(p, a < 0);
  endfunction

  function automatic longint acc_sat(longint acc, longint v);
    longint s;
    s = acc + v;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  // one home atom against one neighbor position
  function automatic void pair_force(int h, longint nx, longint ny, longint nz);
    longint dx, dy, dz, r6, e, a, c;
    longint unsigned r2;
    dx = hx[h] - nx;
    dy = hy[h] - ny;
    dz = hz[h] - nz;
    r2 = longint'(qmul(dx, dx, 16)) + qmul(dy, dy, 16) + qmul(dz, dz, 16);
    if (r2 == 0 || r2 > cut2) return;
    r6 = sig6;
    for (int i = 0; i < 3; i++) begin
      r6 = qdiv(r6, r2);
      if (r6 > 64'sh0FFFF_FFFF) r6 = 64'sh0FFFF_FFFF;
    end
    e = qmul(r6, r6 - ONE_Q, 8) - eshift * 256;
    e = e / 2;
    ae[h] = acc_sat(ae[h], e);
    a = qmul(eps4, r6, 16);
    a = qdiv(a, r2);
    c = qmul(a, 12 * r6 - 6 * ONE_Q, 16);
    ax[h] = acc_sat(ax[h], qmul(dx, c, 8));
    ay[h] = acc_sat(ay[h], qmul(dy, c, 8));
    az[h] = acc_sat(az[h], qmul(dz, c, 8));
  endfunction

  // apply one accepted item to the predictor
  function automatic void lj_apply(item_t it);
    sums_t s;
    case (it.req)
      REQ_LOAD: begin
        hx[it.idx] = it.x;
        hy[it.idx] = it.y;
        hz[it.idx] = it.z;
        ax[it.idx] = 0;
        ay[it.idx] = 0;
        az[it.idx] = 0;
        ae[it.idx] = 0;
        atom_count = it.idx + 1;
      end
      REQ_INTERACT: begin
        for (int h = 0; h < atom_count; h++)
          if (!(it.skip && h == it.idx)) pair_force(h, it.x, it.y, it.z);
      end
      REQ_READ: begin
        s.idx = it.idx;
        s.fx = ax[it.idx][47:0];
        s.fy = ay[it.idx][47:0];
        s.fz = az[it.idx][47:0];
        s.en = ae[it.idx][47:0];
        sums_q.push_back(s);
      end
      default: ;
    endcase
  endfunction

  // accept detection, prediction and timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_n && start && !busy) begin
      lj_apply(cur);
      took = 1;
    end
  end

  // result checker
  always @(posedge clk) begin
    sums_t x;
    if (rst_n && out_valid) begin
      if (sums_q.size() == 0) begin
        $error("unexpected result for atom %0d", out_read_index);
        fails++;
      end else begin
        x = sums_q.pop_front();
        if (out_read_index !== x.idx) begin
          $error("read_index exp %0d got %0d", x.idx, out_read_index); fails++;
        end
        if (out_force_x !== x.fx) begin
          $error("force_x exp %0d got %0d", x.fx, out_force_x); fails++;
        end
        if (out_force_y !== x.fy) begin
          $error("force_y exp %0d got %0d", x.fy, out_force_y); fails++;
        end
        if (out_force_z !== x.fz) begin
          $error("force_z exp %0d got %0d", x.fz, out_force_z); fails++;
        end
        if (out_energy !== x.en) begin
          $error("energy exp %0d got %0d", x.en, out_energy); fails++;
        end
      end
    end
  end

  // item driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (took) begin
        took = 0;
        hold = 0;
        gap = burst ? 0 : $urandom_range(0, 5);
      end
      if (!hold) begin
        if (gap > 0) gap--;
        else if (pending.size() > 0) begin
          cur = pending.pop_front();
          hold = 1;
          in_req_type   <= cur.req;
          in_atom_index <= cur.idx;
          in_pos_x      <= cur.x;
          in_pos_y      <= cur.y;
          in_pos_z      <= cur.z;
          in_skip_valid <= cur.skip;
        end
      end
      start <= hold;
    end
  end

  task automatic push(logic [1:0] req, logic [5:0] idx, logic signed [31:0] x,
                      logic signed [31:0] y, logic signed [31:0] z, logic skip);
    item_t it;
    it.req = req; it.idx = idx; it.x = x; it.y = y; it.z = z; it.skip = skip;
    if (req == REQ_LOAD && idx + 1 > loaded) loaded = idx + 1;
    pending.push_back(it);
  endtask

  function automatic logic signed [31:0] near(logic signed [31:0] c);
    return c + $signed($urandom_range(0, 262144)) - 32'sd131072;
  endfunction

  // block until every item is taken and every result has come
  task automatic drain();
    while (pending.size() != 0 || hold) @(posedge clk);
    repeat (3) @(posedge clk);
    while (busy || sums_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // one register write; the enable is dropped by the caller after the last one
  task automatic cfg_write(logic [1:0] ix, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_wdata <= v;
    case (ix)
      CFG_SIGMA_SIXTH: sig6 = v;
      CFG_CUTOFF_SQ:   cut2 = v;
      CFG_EPSILON:     eps4 = v;
      default:         eshift = longint'($signed(v));
    endcase
    @(negedge clk);
  endtask

  task automatic set_cfg(logic [31:0] s6, logic [31:0] c2, logic [31:0] e4, logic [31:0] sh);
    cfg_write(CFG_SIGMA_SIXTH, s6);
    cfg_write(CFG_CUTOFF_SQ, c2);
    cfg_write(CFG_EPSILON, e4);
    cfg_write(CFG_ENERGY_SHIFT, sh);
    cfg_we <= 1'b0;
  endtask

  // random traffic: mostly load-interact-read sequences, some noise
  task automatic random_items(int n);
    int done, na, k;
    logic signed [31:0] cx, cy, cz;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 99) < 70) begin
        na = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        if ($urandom_range(0, 7) == 0) begin
          cx = $urandom; cy = $urandom; cz = $urandom;
        end else begin
          cx = $signed($urandom_range(0, 2097152)) - 32'sd1048576;
          cy = $signed($urandom_range(0, 2097152)) - 32'sd1048576;
          cz = $signed($urandom_range(0, 2097152)) - 32'sd1048576;
        end
        for (int i = 0; i < na; i++) push(REQ_LOAD, i, near(cx), near(cy), near(cz), $urandom);
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
          push(REQ_INTERACT, ($urandom_range(0, 1) ? $urandom_range(0, na - 1) : $urandom),
               near(cx), near(cy), near(cz), $urandom);
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) push(REQ_READ, $urandom_range(0, na - 1), $urandom,
                                         $urandom, $urandom, $urandom);
        done += na + 6;
      end else begin
        case ($urandom_range(0, 3))
          0: push(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
          1: begin
            push(REQ_READ, $urandom_range(0, loaded - 1), $urandom, $urandom, $urandom,
                 $urandom);
            done++;
          end
          2: begin
            push(REQ_INTERACT, $urandom, $urandom, $urandom, $urandom, $urandom);
            done++;
          end
          default: begin
            push(REQ_LOAD, $urandom_range(0, (loaded < 63) ? loaded : 63), $urandom,
                 $urandom, $urandom, $urandom);
            done++;
          end
        endcase
      end
    end
  endtask

  initial begin
    sig6 = 0; cut2 = 0; eps4 = 0; eshift = 0; atom_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, each request, coincident, skipped self, out of cutoff, unknown
    set_cfg(32'd65536, 32'd409600, 32'd262144, 32'd0);
    push(REQ_LOAD, 0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    push(REQ_LOAD, 1, 32'sd65536, 32'sd32768, -32'sd16384, 1'b1);
    push(REQ_LOAD, 2, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF, 1'b0);
    push(REQ_INTERACT, 6'd63, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    push(REQ_INTERACT, 6'd1, 32'sd65536, 32'sd32768, -32'sd16384, 1'b1);
    push(REQ_INTERACT, 6'd0, 32'sd0, 32'sd0, 32'sd2000000, 1'b0);
    push(REQ_INTERACT, 6'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1, 1'b0);
    push(2'd3, 6'h3F, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1);
    push(REQ_READ, 0, 0, 0, 0, 1'b0);
    push(REQ_READ, 1, 0, 0, 0, 1'b0);
    push(REQ_READ, 2, 0, 0, 0, 1'b0);
    push(REQ_LOAD, 0, 32'sd16384, 32'sd16384, 32'sd16384, 1'b0);
    push(REQ_INTERACT, 6'd0, 32'sd24000, 32'sd16384, 32'sd16384, 1'b0);
    push(REQ_READ, 0, 0, 0, 0, 1'b0);
    drain();

    // full set of atoms, highest index
    for (int i = 0; i < NUM_ATOMS; i++)
      push(REQ_LOAD, i, i * 32'sd200000, -i * 32'sd70000, 32'sd0, 1'b0);
    push(REQ_INTERACT, 6'd63, 32'sd100000, 32'sd0, 32'sd0, 1'b1);
    push(REQ_READ, 6'd63, 0, 0, 0, 1'b0);
    push(REQ_READ, 6'd0, 0, 0, 0, 1'b0);
    burst = 1;
    random_items(250);
    drain();
    burst = 0;

    // saturation extremes
    set_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    random_items(250);
    drain();

    set_cfg($urandom_range(0, 1 << 20), $urandom_range(1 << 17, 1 << 21), $urandom,
            32'h8000_0000);
    random_items(250);
    drain();

    set_cfg(32'd0, 32'd0, 32'd0, 32'd0);
    random_items(150);
    drain();

    set_cfg($urandom, $urandom, $urandom, $urandom);
    random_items(250);
    drain();

    set_cfg(32'd65536, 32'd1000000, 32'd262144, $urandom);
    random_items(250);
    drain();

    repeat (20) @(posedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ljpfa_pkg.sv
rtl/core/ljpfa_mul.sv
rtl/core/ljpfa_div.sv
rtl/core/ljpfa_dp.sv
rtl/core/ljpfa_ctrl.sv
rtl/core/lennard_jones_pair_force_accumulator.sv
tb/sv/tb.sv
